// File: rtl/core/ecfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecfr_pkg
// Shared types and constants of the escape-command frame receiver.
// ----------------------------------------------------------------------------
package ecfr_pkg;

	localparam logic [7:0]  ESC_BYTE = 8'hB0;
	localparam logic [31:0] CMD_BOOT = 32'h0000_02B0;
	localparam logic [31:0] CMD_OPEN = 32'h0101_02B0;
	localparam logic [31:0] CMD_READ = 32'h0103_02B0;

	localparam int unsigned OUT_TDATA_W = 48;

	// receiver modes
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_COMMAND = 3'd1,
		MODE_LENGTH  = 3'd2,
		MODE_PAYLOAD = 3'd3,
		MODE_CHECK   = 3'd4
	} mode_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_CONSOLE = 3'd0,
		KIND_BOOT    = 3'd1,
		KIND_START   = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_GOOD    = 3'd4,
		KIND_BAD     = 3'd5,
		KIND_UNKNOWN = 3'd6
	} kind_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        command_id;
		logic [31:0] command_word;
		logic        last_payload;
	} result_t;

endpackage

// File: rtl/core/escape_command_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_command_frame_receiver
// Splits a serial byte stream into console bytes, commands and checked frames.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register, then is decoded into the
//   result register, which shows the result on the master side; a held result
//   keeps the byte waiting in the input register.
// Throughput: one byte per cycle while the master side takes every item; a held
//   result stalls the input stage.
// Reset: arst_n clears valid flags and decoder state; mode resets to normal.
// ----------------------------------------------------------------------------
module escape_command_frame_receiver import ecfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] rx_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] data_byte, [8] command_id,
	                                              // [40:9] command_word, [47:41] zero
	output logic [2:0]             m_axis_tuser,  // [2:0] kind
	output logic                   m_axis_tlast   // last_payload
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       space;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// decode a held byte whenever the result register can take its result
	assign step = valid_s1 && space;

	ecfr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ecfr_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ecfr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.load_valid (res_valid),
		.load_res   (res),
		.space      (space),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	// pack the result item
	assign m_axis_tdata = {7'd0, out_res.command_word, out_res.command_id, out_res.data_byte};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_payload;

`ifndef SYNTHESIS
	// an empty input stage always takes a byte
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// a held byte with room downstream is decoded in the same cycle
	a_step_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!m_axis_tvalid || m_axis_tready)) |-> step)
		else $error("held byte not decoded despite room");

	// last flag only on payload items
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_PAYLOAD))
		else $error("last flag on non-payload item");

	// command word only on unknown-command items
	a_word_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[40:9] != 32'd0))
		|-> (m_axis_tuser == KIND_UNKNOWN))
		else $error("command word on wrong item kind");

	// a decoded result is shown in the next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |=> m_axis_tvalid)
		else $error("decoded result lost");
`endif

endmodule

// File: rtl/core/ecfr_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecfr_in_reg
// Input stage: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module ecfr_in_reg import ecfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// accept when empty or when the held item leaves this cycle
	assign in_ready = !valid_s1 || take;

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// capture the byte
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// File: rtl/core/ecfr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecfr_decode
// Command and frame state machine: one byte per step, at most one result.
// ----------------------------------------------------------------------------
module ecfr_decode import ecfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	mode_t       mode_q, mode_d;
	logic [1:0]  pos_q, pos_d;
	logic [23:0] partial_q, partial_d;
	logic        fcmd_q, fcmd_d;
	logic [31:0] flen_q, flen_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] sum_q, sum_d;
	logic [23:0] check_q, check_d;

	logic [4:0]  shift;
	logic [31:0] word;
	logic [31:0] full_len;
	logic [31:0] got;
	logic [31:0] sum_add;
	logic [31:0] remain_dec;

	assign shift      = {pos_q, 3'b000};
	assign word       = {rx_byte, partial_q[15:0], ESC_BYTE};
	assign full_len   = {rx_byte, flen_q[23:0]};
	assign got        = {rx_byte, check_q};
	assign sum_add    = sum_q + {24'd0, rx_byte};
	assign remain_dec = remain_q - 32'd1;

	// next state
	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		partial_d = partial_q;
		fcmd_d    = fcmd_q;
		flen_d    = flen_q;
		remain_d  = remain_q;
		sum_d     = sum_q;
		check_d   = check_q;
		case (mode_q)
			MODE_COMMAND: begin
				sum_d = sum_add;
				if (pos_q < 2'd2) begin
					partial_d = partial_q | (24'(rx_byte) << shift);
					pos_d     = pos_q + 2'd1;
				end else begin
					pos_d     = 2'd0;
					partial_d = '0;
					if (word == CMD_OPEN || word == CMD_READ) begin
						fcmd_d = (word == CMD_READ);
						flen_d = '0;
						mode_d = MODE_LENGTH;
					end else begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			MODE_LENGTH: begin
				sum_d = sum_add;
				if (pos_q < 2'd3) begin
					flen_d = flen_q | (32'(rx_byte) << shift);
					pos_d  = pos_q + 2'd1;
				end else begin
					flen_d   = full_len;
					pos_d    = 2'd0;
					remain_d = full_len;
					check_d  = '0;
					mode_d   = (full_len == 32'd0) ? MODE_CHECK : MODE_PAYLOAD;
				end
			end
			MODE_PAYLOAD: begin
				sum_d    = sum_add;
				remain_d = remain_dec;
				if (remain_dec == 32'd0) begin
					mode_d  = MODE_CHECK;
					pos_d   = 2'd0;
					check_d = '0;
				end
			end
			MODE_CHECK: begin
				if (pos_q < 2'd3) begin
					check_d = check_q | (24'(rx_byte) << shift);
					pos_d   = pos_q + 2'd1;
				end else begin
					pos_d   = 2'd0;
					check_d = '0;
					mode_d  = MODE_NORMAL;
				end
			end
			default: begin
				if (rx_byte == ESC_BYTE) begin
					mode_d    = MODE_COMMAND;
					sum_d     = {24'd0, ESC_BYTE};
					pos_d     = 2'd0;
					partial_d = '0;
				end else begin
					mode_d = MODE_NORMAL;
					sum_d  = sum_add;
				end
			end
		endcase
	end

	// result for the current byte
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (mode_q)
			MODE_COMMAND: begin
				if (pos_q == 2'd2) begin
					res_valid = 1'b1;
					if (word == CMD_BOOT) begin
						res.kind = KIND_BOOT;
					end else if (word == CMD_OPEN || word == CMD_READ) begin
						res.kind       = KIND_START;
						res.command_id = (word == CMD_READ);
					end else begin
						res.kind         = KIND_UNKNOWN;
						res.command_word = word;
					end
				end
			end
			MODE_LENGTH: begin
				res_valid = 1'b0;
			end
			MODE_PAYLOAD: begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.data_byte    = rx_byte;
				res.command_id   = fcmd_q;
				res.last_payload = (remain_dec == 32'd0);
			end
			MODE_CHECK: begin
				if (pos_q == 2'd3) begin
					res_valid      = 1'b1;
					res.kind       = (got == sum_q) ? KIND_GOOD : KIND_BAD;
					res.command_id = fcmd_q;
				end
			end
			default: begin
				if (rx_byte != ESC_BYTE) begin
					res_valid     = 1'b1;
					res.kind      = KIND_CONSOLE;
					res.data_byte = rx_byte;
				end
			end
		endcase
	end

	// hold state between steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			pos_q     <= '0;
			partial_q <= '0;
			fcmd_q    <= 1'b0;
			flen_q    <= '0;
			remain_q  <= '0;
			sum_q     <= '0;
			check_q   <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			partial_q <= partial_d;
			fcmd_q    <= fcmd_d;
			flen_q    <= flen_d;
			remain_q  <= remain_d;
			sum_q     <= sum_d;
			check_q   <= check_d;
		end
	end

endmodule

// File: rtl/core/ecfr_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecfr_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module ecfr_out_reg import ecfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    load_valid,
	input  result_t load_res,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	// free when empty or drained this cycle
	assign space = !out_valid || out_ready;

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (space) begin
			out_valid <= load && load_valid;
		end
	end

	// capture the result
	always_ff @(posedge clk) begin
		if (space && load && load_valid) begin
			out_res <= load_res;
		end
	end

endmodule

// File: tb/sv/escape_command_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_command_frame_receiver_test
// Drives serial bytes into the escape-command frame receiver and checks every
// result item against a cycle-free model of the decoder, or against the
// expected item of a typed row in the short table of directed bytes that comes
// first. Random console bytes, commands and frames follow, with good and
// spoiled checksums. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module escape_command_frame_receiver_test;
	import ecfr_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;  // [7:0] rx_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [7:0] data_byte, [8] command_id,
	                                       // [40:9] command_word, [47:41] zero
	logic [2:0]             m_axis_tuser;  // [2:0] kind
	logic                   m_axis_tlast;  // last_payload

	escape_command_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// one row of the directed table
	typedef struct {
		logic [7:0] rx;
		bit         typed;
		result_t    want;
	} dir_row_t;

	dir_row_t    dir_rows[$];
	result_t     pending_results[$];
	int unsigned bytes_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned sender_calm = 0;
	int unsigned sink_calm = 0;

	// decoder state as the block should hold it
	mode_t       rx_mode = MODE_NORMAL;
	logic [1:0]  field_pos = 2'd0;
	logic [23:0] cmd_bytes = 24'd0;
	logic        frame_is_read = 1'b0;
	logic [31:0] frame_len = 32'd0;
	logic [31:0] bytes_left = 32'd0;
	logic [31:0] byte_sum = 32'd0;
	logic [23:0] check_bytes = 24'd0;

	// advance the decoder by one byte; returns 1 when a result item is due
	function automatic bit decode_rx_byte(input logic [7:0] b, output result_t r);
		logic [31:0] word;
		logic [31:0] got;
		r = '0;
		decode_rx_byte = 1'b0;
		case (rx_mode)
			MODE_COMMAND: begin
				byte_sum = byte_sum + b;
				cmd_bytes = cmd_bytes | ({16'd0, b} << (8 * field_pos));
				if (field_pos < 2'd2) begin
					field_pos = field_pos + 2'd1;
				end else begin
					word = {cmd_bytes, ESC_BYTE};
					field_pos = 2'd0;
					cmd_bytes = 24'd0;
					decode_rx_byte = 1'b1;
					if (word == CMD_BOOT) begin
						rx_mode = MODE_NORMAL;
						r.kind = KIND_BOOT;
					end else if (word == CMD_OPEN || word == CMD_READ) begin
						frame_is_read = (word == CMD_READ);
						frame_len = 32'd0;
						rx_mode = MODE_LENGTH;
						r.kind = KIND_START;
						r.command_id = frame_is_read;
					end else begin
						rx_mode = MODE_NORMAL;
						r.kind = KIND_UNKNOWN;
						r.command_word = word;
					end
				end
			end
			MODE_LENGTH: begin
				byte_sum = byte_sum + b;
				frame_len = frame_len | ({24'd0, b} << (8 * field_pos));
				if (field_pos < 2'd3) begin
					field_pos = field_pos + 2'd1;
				end else begin
					field_pos = 2'd0;
					bytes_left = frame_len;
					check_bytes = 24'd0;
					rx_mode = (frame_len == 32'd0) ? MODE_CHECK : MODE_PAYLOAD;
				end
			end
			MODE_PAYLOAD: begin
				byte_sum = byte_sum + b;
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 32'd0) begin
					rx_mode = MODE_CHECK;
					field_pos = 2'd0;
					check_bytes = 24'd0;
				end
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.command_id = frame_is_read;
				r.last_payload = (bytes_left == 32'd0);
				decode_rx_byte = 1'b1;
			end
			MODE_CHECK: begin
				if (field_pos < 2'd3) begin
					check_bytes = check_bytes | ({16'd0, b} << (8 * field_pos));
					field_pos = field_pos + 2'd1;
				end else begin
					got = {b, check_bytes};
					field_pos = 2'd0;
					check_bytes = 24'd0;
					rx_mode = MODE_NORMAL;
					r.kind = (got == byte_sum) ? KIND_GOOD : KIND_BAD;
					r.command_id = frame_is_read;
					decode_rx_byte = 1'b1;
				end
			end
			default: begin
				if (b == ESC_BYTE) begin
					rx_mode = MODE_COMMAND;
					byte_sum = {24'd0, ESC_BYTE};
					field_pos = 2'd0;
					cmd_bytes = 24'd0;
				end else begin
					rx_mode = MODE_NORMAL;
					byte_sum = byte_sum + b;
					r.kind = KIND_CONSOLE;
					r.data_byte = b;
					decode_rx_byte = 1'b1;
				end
			end
		endcase
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic add_row(input logic [7:0] rx, input bit typed, input kind_t kind,
			input logic [7:0] data, input logic id, input logic [31:0] word,
			input logic last);
		dir_row_t row;
		row.rx = rx;
		row.typed = typed;
		row.want = '0;
		row.want.kind = kind;
		row.want.data_byte = data;
		row.want.command_id = id;
		row.want.command_word = word;
		row.want.last_payload = last;
		dir_rows.push_back(row);
	endtask

	// offer one byte, wait for the handshake, then log what it should cause
	task automatic send_rx_byte(input logic [7:0] b, input bit typed, input result_t want);
		int unsigned gap;
		result_t     got;
		bit          has;
		if (sender_calm != 0) begin
			sender_calm--;
			gap = 0;
		end else begin
			gap = idle_gap();
			if ($urandom_range(0, 39) == 0)
				sender_calm = 50;
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		has = decode_rx_byte(b, got);
		if (typed)
			pending_results.push_back(want);
		else if (has)
			pending_results.push_back(got);
		bytes_sent++;
	endtask

	task automatic send_command(input logic [31:0] word);
		for (int i = 0; i < 4; i++)
			send_rx_byte(word[8 * i +: 8], 1'b0, '0);
	endtask

	// command, length, payload and checksum; a spoiled checksum has one bit flipped
	task automatic send_frame(input bit is_read, input logic [31:0] len, input bit spoil);
		logic [31:0] word;
		logic [31:0] sum;
		logic [7:0]  b;
		word = is_read ? CMD_READ : CMD_OPEN;
		sum = 32'd0;
		for (int i = 0; i < 4; i++) begin
			b = word[8 * i +: 8];
			sum = sum + b;
			send_rx_byte(b, 1'b0, '0);
		end
		for (int i = 0; i < 4; i++) begin
			b = len[8 * i +: 8];
			sum = sum + b;
			send_rx_byte(b, 1'b0, '0);
		end
		for (int i = 0; i < len; i++) begin
			b = ($urandom_range(0, 7) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255));
			sum = sum + b;
			send_rx_byte(b, 1'b0, '0);
		end
		if (spoil)
			sum = sum ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			send_rx_byte(sum[8 * i +: 8], 1'b0, '0);
	endtask

	// reset, directed table, random traffic, drain, verdict
	initial begin : stimulus
		int unsigned pick;
		bit          drained_once;
		logic [31:0] word;
		logic [7:0]  b;
		drained_once = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// console extremes, boot, unknown, then a read frame carrying an escape
		// byte as payload and closed by a bad checksum
		add_row(8'h00, 1, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'hFF, 1, KIND_CONSOLE, 8'hFF, 0, 32'd0, 0);
		add_row(8'hB0, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h02, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h00, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h00, 1, KIND_BOOT,    8'h00, 0, 32'd0, 0);
		add_row(8'hB0, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h12, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h34, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h56, 1, KIND_UNKNOWN, 8'h00, 0, 32'h5634_12B0, 0);
		add_row(8'hB0, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h02, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h03, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h01, 1, KIND_START,   8'h00, 1, 32'd0, 0);
		add_row(8'h01, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h00, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h00, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'h00, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'hB0, 1, KIND_PAYLOAD, 8'hB0, 1, 32'd0, 1);
		add_row(8'hFF, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'hFF, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'hFF, 0, KIND_CONSOLE, 8'h00, 0, 32'd0, 0);
		add_row(8'hFF, 1, KIND_BAD,     8'h00, 1, 32'd0, 0);
		foreach (dir_rows[i])
			send_rx_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

		// random traffic, mostly well-formed frames and commands
		while (bytes_sent < 1650) begin
			if (!drained_once && bytes_sent >= 800) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
				drained_once = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_frame(1'($urandom_range(0, 1)),
					($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(0, 6),
					$urandom_range(0, 4) == 0);
			end else if (pick < 55) begin
				send_command(CMD_BOOT);
			end else if (pick < 70) begin
				// near misses of the known words, or anything after the escape byte
				do begin
					if ($urandom_range(0, 1) == 0) begin
						case ($urandom_range(0, 2))
							0: word = CMD_BOOT;
							1: word = CMD_OPEN;
							default: word = CMD_READ;
						endcase
						word = word ^ (32'd1 << $urandom_range(8, 31));
					end else begin
						word = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)), ESC_BYTE};
					end
				end while (word == CMD_OPEN || word == CMD_READ);
				send_command(word);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					do b = 8'($urandom_range(0, 255)); while (b == ESC_BYTE);
					send_rx_byte(b, 1'b0, '0);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("escape_command_frame_receiver_test: PASS");
		else
			$display("escape_command_frame_receiver_test: FAIL");
		$finish;
	end

	// random back-pressure, with one long hold-off once results are flowing
	initial begin : sink
		int unsigned stall;
		bit          held_off;
		held_off = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!held_off && results_seen >= 400) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				if (sink_calm != 0) begin
					sink_calm--;
					stall = 0;
				end else begin
					stall = idle_gap();
					if ($urandom_range(0, 39) == 0)
						sink_calm = 60;
				end
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// compare each result item with the oldest expectation
	result_t want;
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: kind %0d data %02h id %0d word %08h last %0d",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
						m_axis_tdata[40:9], m_axis_tlast);
			end else begin
				want = pending_results.pop_front();
				if ({m_axis_tuser, m_axis_tdata, m_axis_tlast} !==
						{want.kind, 7'd0, want.command_word, want.command_id,
						want.data_byte, want.last_payload}) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: want kind %0d data %02h id %0d word %08h last %0d",
							$realtime, want.kind, want.data_byte, want.command_id,
							want.command_word, want.last_payload);
						$display("  got kind %0d data %02h id %0d word %08h last %0d pad %02h",
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
							m_axis_tdata[40:9], m_axis_tlast, m_axis_tdata[47:41]);
					end
				end
			end
		end
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("escape_command_frame_receiver_test: FAIL");
		$finish;
	end

endmodule
